@@ hdl/ppi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the particle pool integrator.
package ppi_pkg;
   localparam int POOL_DEPTH = 64;
   localparam int SLOT_W = 6;
   localparam logic [19:0] AGE_MAX = 20'hFFFFF;
   localparam logic [19:0] AGE_RESET = 20'h10000;
   localparam logic [15:0] DRAG_RESET = 16'd61604;
   localparam logic ACT_SPAWN = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [31:0] spawn_pos_x;
      logic signed [31:0] spawn_pos_y;
      logic signed [31:0] spawn_vel_x;
      logic signed [31:0] spawn_vel_y;
      logic [19:0]        life_span;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic [23:0]        pull_accel;
      logic [15:0]        tick_dt;
   } req_type;

   typedef struct packed {
      logic [5:0]         slot_index;
      logic               alive;
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic [19:0]        out_age;
      logic               last_slot;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

@@ hdl/ppi_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
interface ppi_req_if;
   import ppi_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppi_rsp_if;
   import ppi_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/ppi_divsqrt.sv @@
`timescale 1ns / 1ps
// Shared iterative unit: 64-bit integer square root or 64/64 division, one bit a cycle.
module ppi_divsqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        op_sqrt,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] result
);
   logic [63:0] x_ff, x_in, r_ff, r_in, b_ff, b_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, sq_ff, sq_in, done_ff, done_in;
   logic [64:0] rem_sh;

   always_comb begin
      x_in = x_ff; r_in = r_ff; b_in = b_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; sq_in = sq_ff; done_in = 1'b0;
      rem_sh = {b_ff, x_ff[63]};
      if (start) begin
         x_in = num; d_in = den; r_in = '0; sq_in = op_sqrt; busy_in = 1'b1;
         b_in = op_sqrt ? 64'h4000_0000_0000_0000 : 64'd0;
         cnt_in = op_sqrt ? 7'd32 : 7'd64;
      end else if (busy_ff) begin
         if (sq_ff) begin
            if (x_ff >= r_ff + b_ff) begin
               x_in = x_ff - (r_ff + b_ff);
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in = b_ff >> 2;
         end else begin
            // b holds partial remainder, x shifts out the dividend, r builds quotient
            x_in = {x_ff[62:0], 1'b0};
            if (rem_sh >= {1'b0, d_ff}) begin
               b_in = 64'(rem_sh - {1'b0, d_ff});
               r_in = {r_ff[62:0], 1'b1};
            end else begin
               b_in = rem_sh[63:0];
               r_in = {r_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in; r_ff <= r_in; b_ff <= b_in; d_ff <= d_in; sq_ff <= sq_in;
   end

   assign done = done_ff;
   assign result = r_ff;
endmodule

@@ hdl/particle_pool_integrator.sv @@
`timescale 1ns / 1ps
// Top level: particle pool with sequenced Euler integration.
// A spawn beat is taken while idle and writes the next ring slot. A tick beat
// walks all 64 slots one at a time and emits one response beat per slot. A live
// gravity slot runs setup, a 32-step square root and two 64-step divisions (each
// skipped when its quotient is known zero) on the shared divide/root unit, then the
// update and output. A gravity slot within 256 position units of its target skips
// the pull, a linear slot has none and a dead slot goes straight to output; any slot
// can also wait on a response stall. The request side is not ready while a tick runs.
module particle_pool_integrator (
   input  logic            clock,
   input  logic            reset,
   ppi_req_if.sink         req,
   ppi_rsp_if.source       rsp,
   input  logic            csr_we,
   input  logic [15:0]     csr_wdata
);
   import ppi_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_LD, S_DIF, S_SHF, S_SQA, S_SQB, S_CHK, S_AD, S_SQR, S_DVX,
      S_DVY, S_PULL, S_MVX, S_MVY, S_DRX, S_DRY, S_WB, S_OUT
   } state_type;

   logic [31:0] m_px [POOL_DEPTH], m_py [POOL_DEPTH], m_vx [POOL_DEPTH], m_vy [POOL_DEPTH];
   logic [31:0] m_gx [POOL_DEPTH], m_gy [POOL_DEPTH];
   logic [23:0] m_ac [POOL_DEPTH];
   logic [19:0] m_age [POOL_DEPTH], m_life [POOL_DEPTH];
   logic [POOL_DEPTH-1:0] wr_ok_ff;

   state_type state_ff;
   logic [15:0] drag_ff;
   logic [SLOT_W-1:0] wslot_ff, slot_ff;
   logic [15:0] dt_ff;
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff, gx_ff, gy_ff;
   logic [23:0] ac_ff;
   logic [19:0] age_ff, life_ff;
   logic live_ff, sgx_ff, sgy_ff, big_ff, run_ff;
   logic [32:0] ax_ff, ay_ff;
   logic [63:0] dsq_ff, prod_ff, d_ff, ad_ff, ix_ff, iy_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        ds_start, ds_sqrt, ds_done;
   logic [63:0] ds_num, ds_den, ds_res;
   logic [20:0] age_sum;

   ppi_divsqrt u_ds (
      .clock, .reset, .start(ds_start), .op_sqrt(ds_sqrt), .num(ds_num), .den(ds_den),
      .done(ds_done), .result(ds_res)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;
   assign age_sum = {1'b0, age_ff} + {5'd0, dt_ff};

   function automatic logic signed [63:0] trq16(input logic signed [63:0] p);
      logic [63:0] m;
      m = p[63] ? 64'(-p) : 64'(p);
      m = m >> 16;
      return p[63] ? -$signed(m) : $signed(m);
   endfunction

   always_comb begin
      ds_start = 1'b0; ds_sqrt = 1'b0; ds_num = dsq_ff; ds_den = d_ff;
      unique case (state_ff)
         S_SQR: begin ds_start = !run_ff; ds_sqrt = 1'b1; end
         S_DVX, S_DVY: begin
            ds_start = !run_ff && (prod_ff != 64'd0);
            ds_num = prod_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         drag_ff <= DRAG_RESET;
         wslot_ff <= '0;
         wr_ok_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) drag_ff <= csr_wdata;
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               if (req.data.action == ACT_SPAWN) begin
                  m_px[wslot_ff] <= req.data.spawn_pos_x;
                  m_py[wslot_ff] <= req.data.spawn_pos_y;
                  m_vx[wslot_ff] <= req.data.spawn_vel_x;
                  m_vy[wslot_ff] <= req.data.spawn_vel_y;
                  m_gx[wslot_ff] <= req.data.goal_x;
                  m_gy[wslot_ff] <= req.data.goal_y;
                  m_ac[wslot_ff] <= req.data.pull_accel;
                  m_life[wslot_ff] <= req.data.life_span;
                  m_age[wslot_ff] <= '0;
                  wr_ok_ff[wslot_ff] <= 1'b1;
                  wslot_ff <= (wslot_ff == SLOT_W'(POOL_DEPTH - 1)) ? '0 : wslot_ff + 1'b1;
               end else begin
                  dt_ff <= req.data.tick_dt;
                  slot_ff <= '0;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               px_ff <= m_px[slot_ff]; py_ff <= m_py[slot_ff];
               vx_ff <= m_vx[slot_ff]; vy_ff <= m_vy[slot_ff];
               gx_ff <= m_gx[slot_ff]; gy_ff <= m_gy[slot_ff];
               ac_ff <= m_ac[slot_ff];
               age_ff <= wr_ok_ff[slot_ff] ? m_age[slot_ff] : AGE_RESET;
               life_ff <= wr_ok_ff[slot_ff] ? m_life[slot_ff] : 20'd0;
               state_ff <= S_LD;
            end
            S_LD: begin
               live_ff <= age_ff < life_ff;
               if (age_ff < life_ff) begin
                  age_ff <= age_sum[20] ? AGE_MAX : age_sum[19:0];
                  state_ff <= (ac_ff != 24'd0) ? S_DIF : S_MVX;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_DIF: begin
               sgx_ff <= ($signed({gx_ff[31], gx_ff}) - $signed({px_ff[31], px_ff})) < 0;
               sgy_ff <= ($signed({gy_ff[31], gy_ff}) - $signed({py_ff[31], py_ff})) < 0;
               ax_ff <= ($signed({gx_ff[31], gx_ff}) - $signed({px_ff[31], px_ff})) < 0
                  ? 33'(-($signed({gx_ff[31], gx_ff}) - $signed({px_ff[31], px_ff})))
                  : 33'($signed({gx_ff[31], gx_ff}) - $signed({px_ff[31], px_ff}));
               ay_ff <= ($signed({gy_ff[31], gy_ff}) - $signed({py_ff[31], py_ff})) < 0
                  ? 33'(-($signed({gy_ff[31], gy_ff}) - $signed({py_ff[31], py_ff})))
                  : 33'($signed({gy_ff[31], gy_ff}) - $signed({py_ff[31], py_ff}));
               state_ff <= S_SHF;
            end
            S_SHF: begin
               // magnitudes stay below 2^32, so one shift suffices
               if (ax_ff[31] || ay_ff[31]) begin
                  ax_ff <= ax_ff >> 1; ay_ff <= ay_ff >> 1; big_ff <= 1'b1;
               end else begin
                  big_ff <= 1'b0;
               end
               state_ff <= S_SQA;
            end
            S_SQA: begin
               dsq_ff <= 64'(ax_ff[31:0] * ax_ff[31:0]);
               state_ff <= S_SQB;
            end
            S_SQB: begin
               dsq_ff <= dsq_ff + 64'(ay_ff[31:0] * ay_ff[31:0]);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               state_ff <= (!big_ff && dsq_ff <= 64'd65536) ? S_MVX : S_AD;
            end
            S_AD: begin
               ad_ff <= 64'((40'(ac_ff) * 40'(dt_ff)) >> 16);
               d_ff <= '0;
               run_ff <= 1'b0;
               state_ff <= S_SQR;
            end
            S_SQR: begin
               if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (ds_done) begin
                  d_ff <= ds_res;
                  prod_ff <= 64'(ax_ff[31:0] * ad_ff[31:0]);
                  run_ff <= 1'b0;
                  state_ff <= S_DVX;
               end
            end
            S_DVX: begin
               if (prod_ff == 64'd0) begin
                  ix_ff <= '0;
                  prod_ff <= 64'(ay_ff[31:0] * ad_ff[31:0]);
                  run_ff <= 1'b0;
                  state_ff <= S_DVY;
               end else if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (ds_done) begin
                  ix_ff <= ds_res;
                  prod_ff <= 64'(ay_ff[31:0] * ad_ff[31:0]);
                  run_ff <= 1'b0;
                  state_ff <= S_DVY;
               end
            end
            S_DVY: begin
               if (prod_ff == 64'd0) begin
                  iy_ff <= '0; state_ff <= S_PULL;
               end else if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (ds_done) begin
                  iy_ff <= ds_res; run_ff <= 1'b0; state_ff <= S_PULL;
               end
            end
            S_PULL: begin
               vx_ff <= sat32(66'($signed({vx_ff[31], vx_ff}))
                  + (sgx_ff ? -66'($signed({1'b0, ix_ff})) : 66'($signed({1'b0, ix_ff}))));
               vy_ff <= sat32(66'($signed({vy_ff[31], vy_ff}))
                  + (sgy_ff ? -66'($signed({1'b0, iy_ff})) : 66'($signed({1'b0, iy_ff}))));
               state_ff <= S_MVX;
            end
            S_MVX: begin
               px_ff <= sat32(66'(px_ff) + 66'(trq16(64'(vx_ff * $signed({1'b0, dt_ff})))));
               state_ff <= S_MVY;
            end
            S_MVY: begin
               py_ff <= sat32(66'(py_ff) + 66'(trq16(64'(vy_ff * $signed({1'b0, dt_ff})))));
               state_ff <= (ac_ff == 24'd0) ? S_DRX : S_WB;
            end
            S_DRX: begin
               vx_ff <= sat32(66'(trq16(64'(vx_ff * $signed({1'b0, drag_ff})))));
               state_ff <= S_DRY;
            end
            S_DRY: begin
               vy_ff <= sat32(66'(trq16(64'(vy_ff * $signed({1'b0, drag_ff})))));
               state_ff <= S_WB;
            end
            S_WB: begin
               m_px[slot_ff] <= px_ff; m_py[slot_ff] <= py_ff;
               m_vx[slot_ff] <= vx_ff; m_vy[slot_ff] <= vy_ff;
               m_age[slot_ff] <= age_ff;
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.slot_index <= 6'(slot_ff);
               rsp_ff.alive <= age_ff < life_ff;
               rsp_ff.out_pos_x <= live_ff ? px_ff : '0;
               rsp_ff.out_pos_y <= live_ff ? py_ff : '0;
               rsp_ff.out_age <= age_ff;
               rsp_ff.last_slot <= (slot_ff == SLOT_W'(POOL_DEPTH - 1));
               if (slot_ff == SLOT_W'(POOL_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  slot_ff <= slot_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
